// File: src/pbd_pkg.sv
// pbd_pkg: shared types and constants for the windowed pid balance drive
// no dependencies; imported by every module of the block

package pbd_pkg;

   // signed error sample - setpoint, and the difference of two errors
   typedef logic signed [8:0] err_type;
   typedef logic signed [9:0] diff_type;

   // handshake control handed to each pipeline stage
   typedef struct packed {
      logic valid;   // upstream stage holds a transaction
      logic en;      // this stage may load this cycle
   } stage_ctl_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_DUTY = 3'd4;

   // reset values
   localparam logic [7:0] SETPOINT_RST  = 8'd140;
   localparam logic [9:0] GAIN_P_RST    = 10'd220;
   localparam logic [7:0] GAIN_I_RST    = 8'd30;
   localparam logic [7:0] GAIN_D_RST    = 8'd20;
   localparam logic [7:0] BASE_DUTY_RST = 8'd100;

   // correction word width and the divide by 500
   localparam int ACC_W = 16;
   // x / 500 == (x >> 2) / 125; (x >> 2) < 2^14 keeps the reciprocal exact
   localparam int           QUARTER_W   = ACC_W - 2;
   localparam int           RECIP_W     = 15;
   localparam logic [14:0]  RECIP_MUL   = 15'd16778;   // ceil(2^21 / 125)
   localparam int           RECIP_SHIFT = 21;
   localparam int           PROD_W      = QUARTER_W + RECIP_W;

endpackage

// File: src/windowed_pid_balance_drive_top.sv
// windowed_pid_balance_drive_top: balance controller top level, csr bank
// and pipeline control; depends on pbd_pkg, pbd_front, pbd_mac, pbd_scale
//
// Usage:
// - req channel: one 8-bit tilt sample per transaction (req_valid/req_stall).
// - rsp channel: one transaction per sample with go_backward and duty
//   (rsp_valid/rsp_stall), in the order the samples came in.
// - csr port: write-only; csr_index selects setpoint, gain_p, gain_i, gain_d
//   or base_duty; other indexes are ignored. Write only while no transaction
//   is in flight.
// - three register stages: error/window sum, gain products, divide and
//   duty add. A taken sample passes through them in that order to rsp.
// - throughput is one sample per cycle while rsp_stall is low; each stage
//   loads when empty or when the stage after it moves; a full pipeline streams.
// - when the receiver stalls, the result holds and the stages behind it
//   fill; req_stall rises once all three stages are full.
// - reset (synchronous) empties the pipeline, clears the error history and
//   loads the register reset values.

module windowed_pid_balance_drive_top import pbd_pkg::*; #(
   parameter int WINDOW = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_go_backward,
   output logic [7:0]             rsp_duty,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SUM_W = 9 + $clog2(WINDOW);

   logic [7:0] setpoint_ff;
   logic [9:0] gain_p_ff;
   logic [7:0] gain_i_ff;
   logic [7:0] gain_d_ff;
   logic [7:0] base_duty_ff;

   stage_ctl_type           front_ctl;
   stage_ctl_type           mac_ctl;
   stage_ctl_type           scale_ctl;
   logic                    front_valid;
   logic                    mac_valid;
   logic                    scale_valid;
   err_type                 front_err;
   logic signed [SUM_W-1:0] front_sum;
   diff_type                front_diff;
   logic                    front_backward;
   logic [ACC_W-1:0]        mac_acc;
   logic                    mac_backward;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= SETPOINT_RST;
         gain_p_ff    <= GAIN_P_RST;
         gain_i_ff    <= GAIN_I_RST;
         gain_d_ff    <= GAIN_D_RST;
         base_duty_ff <= BASE_DUTY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETPOINT:  setpoint_ff  <= csr_wdata[7:0];
            CSR_GAIN_P:    gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:    gain_i_ff    <= csr_wdata[7:0];
            CSR_GAIN_D:    gain_d_ff    <= csr_wdata[7:0];
            CSR_BASE_DUTY: base_duty_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // a stage loads when it is empty or its successor loads
   always_comb begin
      scale_ctl.en    = !scale_valid || !rsp_stall;
      scale_ctl.valid = mac_valid;
      mac_ctl.en      = !mac_valid || scale_ctl.en;
      mac_ctl.valid   = front_valid;
      front_ctl.en    = !front_valid || mac_ctl.en;
      front_ctl.valid = req_valid;
   end

   assign req_stall = !front_ctl.en;

   pbd_front #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .ctl      (front_ctl),
      .sample   (req_sample),
      .setpoint (setpoint_ff),
      .valid    (front_valid),
      .err      (front_err),
      .sum      (front_sum),
      .diff     (front_diff),
      .backward (front_backward)
   );

   pbd_mac #(
      .SUM_W (SUM_W)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .err        (front_err),
      .sum        (front_sum),
      .diff       (front_diff),
      .backward_i (front_backward),
      .gain_p     (gain_p_ff),
      .gain_i     (gain_i_ff),
      .gain_d     (gain_d_ff),
      .valid      (mac_valid),
      .acc        (mac_acc),
      .backward   (mac_backward)
   );

   pbd_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scale_ctl),
      .acc        (mac_acc),
      .backward_i (mac_backward),
      .base_duty  (base_duty_ff),
      .valid      (scale_valid),
      .duty       (rsp_duty),
      .backward   (rsp_go_backward)
   );

   assign rsp_valid = scale_valid;

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !front_valid && !mac_valid))
      else $error("pipeline not empty after reset");

   // an empty result stage means the pipeline can always take a sample
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while result stage empty");

   // an accepted transaction lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> front_valid)
      else $error("accepted transaction lost at first stage");

   // a stage that holds data and cannot load keeps its successor full
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (mac_valid && !mac_ctl.en) |-> (rsp_valid && rsp_stall))
      else $error("middle stage blocked without output stall");

endmodule

// File: src/pbd_front.sv
// pbd_front: error forming, error history shift line and windowed sum
// depends on pbd_pkg

module pbd_front import pbd_pkg::*; #(
   parameter int WINDOW = 9,
   parameter int SUM_W  = 9 + $clog2(WINDOW)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stage_ctl_type           ctl,
   input  logic [7:0]              sample,
   input  logic [7:0]              setpoint,
   output logic                    valid,
   output err_type                 err,
   output logic signed [SUM_W-1:0] sum,
   output diff_type                diff,
   output logic                    backward
);

   err_type                 hist_ff [WINDOW];
   err_type                 err_in;
   logic signed [SUM_W-1:0] sum_in;
   logic                    valid_ff;
   err_type                 err_ff;
   logic signed [SUM_W-1:0] sum_ff;
   diff_type                diff_ff;
   logic                    backward_ff;
   logic                    take;

   assign take   = ctl.valid && ctl.en;
   assign err_in = err_type'({1'b0, sample}) - err_type'({1'b0, setpoint});

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < WINDOW; k++) begin
         sum_in = sum_in + SUM_W'(hist_ff[k]);
      end
   end

   // history shifts only when a transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (take) begin
         hist_ff[0] <= err_in;
         for (int k = 1; k < WINDOW; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         err_ff      <= err_in;
         sum_ff      <= sum_in;
         diff_ff     <= diff_type'(err_in) - diff_type'(hist_ff[0]);
         backward_ff <= sample > setpoint;
      end
   end

   assign valid    = valid_ff;
   assign err      = err_ff;
   assign sum      = sum_ff;
   assign diff     = diff_ff;
   assign backward = backward_ff;

endmodule

// File: src/pbd_mac.sv
// pbd_mac: gain products and their 16-bit wrapped sum
// depends on pbd_pkg

module pbd_mac import pbd_pkg::*; #(
   parameter int SUM_W = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stage_ctl_type           ctl,
   input  err_type                 err,
   input  logic signed [SUM_W-1:0] sum,
   input  diff_type                diff,
   input  logic                    backward_i,
   input  logic [9:0]              gain_p,
   input  logic [7:0]              gain_i,
   input  logic [7:0]              gain_d,
   output logic                    valid,
   output logic [ACC_W-1:0]        acc,
   output logic                    backward
);

   logic [ACC_W-1:0] err_x;
   logic [ACC_W-1:0] sum_x;
   logic [ACC_W-1:0] diff_x;
   logic [ACC_W-1:0] p_term;
   logic [ACC_W-1:0] i_term;
   logic [ACC_W-1:0] d_term;
   logic [ACC_W-1:0] acc_in;
   logic             valid_ff;
   logic [ACC_W-1:0] acc_ff;
   logic             backward_ff;

   // only the low 16 bits are kept, so sign-extend and multiply unsigned
   assign err_x  = ACC_W'(err);
   assign sum_x  = ACC_W'(sum);
   assign diff_x = ACC_W'(diff);
   assign p_term = err_x * ACC_W'(gain_p);
   assign i_term = sum_x * ACC_W'(gain_i);
   assign d_term = diff_x * ACC_W'(gain_d);
   assign acc_in = p_term + i_term + d_term;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en && ctl.valid) begin
         acc_ff      <= acc_in;
         backward_ff <= backward_i;
      end
   end

   assign valid    = valid_ff;
   assign acc      = acc_ff;
   assign backward = backward_ff;

endmodule

// File: src/pbd_scale.sv
// pbd_scale: divide by 500, add the base duty, result register
// depends on pbd_pkg

module pbd_scale import pbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  stage_ctl_type    ctl,
   input  logic [ACC_W-1:0] acc,
   input  logic             backward_i,
   input  logic [7:0]       base_duty,
   output logic             valid,
   output logic [7:0]       duty,
   output logic             backward
);

   logic [QUARTER_W-1:0] quarter;
   logic [PROD_W-1:0]    prod;
   logic [7:0]           scaled;
   logic [7:0]           duty_in;
   logic                 valid_ff;
   logic [7:0]           duty_ff;
   logic                 backward_ff;

   // reciprocal multiply; quotient never exceeds 131
   assign quarter = acc[ACC_W-1:2];
   assign prod    = PROD_W'(quarter) * PROD_W'(RECIP_MUL);
   assign scaled  = prod[RECIP_SHIFT +: 8];
   assign duty_in = base_duty + scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en && ctl.valid) begin
         duty_ff     <= duty_in;
         backward_ff <= backward_i;
      end
   end

   assign valid    = valid_ff;
   assign duty     = duty_ff;
   assign backward = backward_ff;

endmodule
